FILE: rtl/hhc_pkg.sv
// Shared types and constants for the height-to-HSV colour pipeline.
package hhc_pkg;

   localparam int HeightW   = 16;
   localparam int RealW     = 24;
   localparam int RgbW      = 24;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 24;

   localparam int HueW      = 8;   // hue in degrees, 0..255
   localparam int BrightW   = 17;  // Q0.16 with room for 1.0
   localparam int ChromaW   = 16;
   localparam int WeightW   = 6;   // 0..60
   localparam int XNumW     = 22;
   localparam int TotW      = 24;

   // restoring divider: brightness takes one overflow step plus 17 quotient bits,
   // hue takes 8 quotient bits in the first stages
   localparam int DivStages = 18;
   localparam int HueSteps  = 8;
   localparam int BrNumW    = 41;
   localparam int HueNumW   = 24;
   localparam int HueDenW   = 17;

   localparam logic [15:0]        SatQ16          = 16'd51773;
   localparam logic [BrightW-1:0] BrightFixedQ16  = 17'd45875;
   localparam logic [BrightW-1:0] BrightFloorQ16  = 17'd16384;
   localparam logic [BrightW-1:0] OneQ16          = 17'd65536;
   localparam logic [HueW-1:0]    HueGrey         = 8'd90;
   localparam logic [HueW-1:0]    HueTop          = 8'd255;
   localparam logic [HueW:0]      HueNegBase      = 9'd140;
   // floor(y / 60) == (y * XRecip) >> XShift for every y below 2**22
   localparam logic [22:0]        XRecip          = 23'd4473925;
   localparam int                 XShift          = 28;

   typedef enum logic [2:0] {
      HUE_FIXED,
      HUE_ZERO,
      HUE_FULL,
      HUE_POS,
      HUE_NEG
   } hue_mode_type;

   typedef enum logic [1:0] {
      BRIGHT_FIXED,
      BRIGHT_ONE,
      BRIGHT_DIV
   } bright_mode_type;

   typedef enum logic [CsrIndexW-1:0] {
      REG_COLOR_ENABLE,
      REG_SHADE_ENABLE,
      REG_MAX_HEIGHT,
      REG_MIN_HEIGHT,
      REG_MIN_REAL_HEIGHT,
      REG_TOTAL_REAL_HEIGHT
   } reg_index_type;

   typedef struct packed {
      hue_mode_type          hue_mode;
      bright_mode_type       bright_mode;
      logic [HueNumW-1:0]    hue_rem;
      logic [HueDenW-1:0]    hue_den;
      logic [HueW-1:0]       hue_quo;
      logic [BrNumW-1:0]     br_rem;
      logic                  br_sat;
      logic [BrightW-1:0]    br_quo;
   } div_type;

endpackage

FILE: rtl/hhc_div_pipe.sv
// Pipelined restoring divider: hue ratio and shading brightness, one bit per stage.
module hhc_div_pipe (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_vld,
   input  hhc_pkg::div_type         in_data,
   input  logic [hhc_pkg::TotW-1:0] total,
   output logic                     out_vld,
   output hhc_pkg::div_type         out_data
);

   logic [hhc_pkg::DivStages-1:0] vld_ff;
   hhc_pkg::div_type              stage_ff  [hhc_pkg::DivStages];
   hhc_pkg::div_type              stage_in  [hhc_pkg::DivStages];
   hhc_pkg::div_type              stage_src [hhc_pkg::DivStages];

   always_comb begin
      stage_src[0] = in_data;
      for (int s = 1; s < hhc_pkg::DivStages; s++) begin
         stage_src[s] = stage_ff[s-1];
      end
   end

   always_comb begin
      logic [hhc_pkg::BrNumW-1:0]  tsh;
      logic [hhc_pkg::HueNumW:0]   dsh;
      logic [hhc_pkg::HueNumW:0]   rext;
      for (int s = 0; s < hhc_pkg::DivStages; s++) begin
         stage_in[s] = stage_src[s];
         tsh = {{(hhc_pkg::BrNumW-hhc_pkg::TotW){1'b0}}, total} << (hhc_pkg::DivStages-1-s);
         if (s == 0) begin
            // first step only detects a quotient above the 17-bit range
            stage_in[s].br_sat = (stage_src[s].br_rem >= tsh);
         end else if (stage_src[s].br_rem >= tsh) begin
            stage_in[s].br_rem = stage_src[s].br_rem - tsh;
            stage_in[s].br_quo = {stage_src[s].br_quo[hhc_pkg::BrightW-2:0], 1'b1};
         end else begin
            stage_in[s].br_quo = {stage_src[s].br_quo[hhc_pkg::BrightW-2:0], 1'b0};
         end

         dsh  = {{(hhc_pkg::HueNumW+1-hhc_pkg::HueDenW){1'b0}}, stage_src[s].hue_den}
                << (hhc_pkg::HueSteps-1-s);
         rext = {1'b0, stage_src[s].hue_rem};
         if (s < hhc_pkg::HueSteps) begin
            if (rext >= dsh) begin
               stage_in[s].hue_rem = hhc_pkg::HueNumW'(rext - dsh);
               stage_in[s].hue_quo = {stage_src[s].hue_quo[hhc_pkg::HueW-2:0], 1'b1};
            end else begin
               stage_in[s].hue_quo = {stage_src[s].hue_quo[hhc_pkg::HueW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[hhc_pkg::DivStages-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < hhc_pkg::DivStages; s++) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign out_vld  = vld_ff[hhc_pkg::DivStages-1];
   assign out_data = stage_ff[hhc_pkg::DivStages-1];

endmodule

FILE: rtl/height_to_hsv_color.sv
// Top level: height-map point to 24-bit RGB colour through an HSV pipeline.
//
//  channel  dir   payload                                   handshake
//  req      in    req_source_height, req_real_height        req_valid / req_ready
//  rsp      out   rsp_rgb_color                             rsp_valid / rsp_ready
//  csr      in    csr_index, csr_write_data                 csr_write_enable
//
// One transaction per clock while the skid register is empty; each result passes through stages 1 and 2,
// the 18-stage restoring divider for the hue ratio and the shading brightness, then stages 3 to 7.
// Synchronous reset empties the pipeline and loads the register defaults.
// A skid register holds one result under back-pressure; while it is full the
// pipeline holds and req_ready is low, so nothing is dropped or repeated.
module height_to_hsv_color (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hhc_pkg::HeightW-1:0]  req_source_height,
   input  logic signed [hhc_pkg::RealW-1:0]    req_real_height,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hhc_pkg::RgbW-1:0]            rsp_rgb_color,
   input  logic                                csr_write_enable,
   input  logic [hhc_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [hhc_pkg::CsrDataW-1:0]        csr_write_data
);

   typedef struct packed {
      hhc_pkg::hue_mode_type    hue_mode;
      hhc_pkg::bright_mode_type bright_mode;
      logic [16:0]              hue_num;
      logic [16:0]              hue_den;
      logic [24:0]              sum;
   } prep_type;

   // configuration registers
   logic                               color_enable_ff;
   logic                               shade_enable_ff;
   logic signed [hhc_pkg::HeightW-1:0] max_height_ff;
   logic signed [hhc_pkg::HeightW-1:0] min_height_ff;
   logic signed [hhc_pkg::RealW-1:0]   min_real_height_ff;
   logic [hhc_pkg::TotW-1:0]           total_real_height_ff;

   logic en;

   // stage 1: case split and height sums
   logic             s1_vld_ff;
   prep_type         prep_in, prep_ff;
   logic [16:0]      neg_z, min_mag;
   logic [23:0]      mr_mag;

   // stage 2: dividends and divisors
   logic             s2_vld_ff;
   hhc_pkg::div_type div_src_in, div_src_ff;
   logic [24:0]      sum_mag;

   logic             div_out_vld;
   hhc_pkg::div_type div_out;

   // stage 3: hue and brightness
   logic                        s3_vld_ff;
   logic [hhc_pkg::HueW-1:0]    s3_hue_in, s3_hue_ff;
   logic [hhc_pkg::BrightW-1:0] s3_bright_in, s3_bright_ff;
   logic [hhc_pkg::HueW:0]      hue_neg_sum;
   logic [hhc_pkg::BrightW-1:0] bright_q;

   // stage 4: chroma and sector weight
   logic                        s4_vld_ff;
   logic [hhc_pkg::HueW-1:0]    s4_hue_ff;
   logic [hhc_pkg::BrightW-1:0] s4_bright_ff;
   logic [hhc_pkg::ChromaW-1:0] s4_chroma_in, s4_chroma_ff;
   logic [hhc_pkg::WeightW-1:0] s4_weight_in, s4_weight_ff;
   logic [32:0]                 chroma_full;
   logic [15:0]                 sat;
   logic [6:0]                  hue_mod;

   // stage 5: minimum and X numerator
   logic                        s5_vld_ff;
   logic [hhc_pkg::HueW-1:0]    s5_hue_ff;
   logic [hhc_pkg::BrightW-1:0] s5_bright_ff;
   logic [hhc_pkg::BrightW-1:0] s5_min_in, s5_min_ff;
   logic [hhc_pkg::XNumW-1:0]   s5_xnum_in, s5_xnum_ff;

   // stage 6: X by reciprocal of 60
   logic                        s6_vld_ff;
   logic [hhc_pkg::HueW-1:0]    s6_hue_ff;
   logic [hhc_pkg::BrightW-1:0] s6_bright_ff;
   logic [hhc_pkg::BrightW-1:0] s6_min_ff;
   logic [hhc_pkg::ChromaW-1:0] s6_x_in, s6_x_ff;
   logic [44:0]                 x_prod;

   // stage 7: channels and sector select
   logic                        s7_vld_ff;
   logic [hhc_pkg::RgbW-1:0]    s7_rgb_in, s7_rgb_ff;
   logic [7:0]                  ch_cm, ch_xm, ch_mm;

   // output skid
   logic                        skid_full_ff;
   logic [hhc_pkg::RgbW-1:0]    skid_rgb_ff;

   function automatic logic [7:0] to_channel(input logic [hhc_pkg::BrightW-1:0] v);
      logic [23:0] t;
      t = ({7'd0, v} << 8) - {7'd0, v} + 24'd32768;
      return t[23:16];
   endfunction

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         color_enable_ff      <= 1'b1;
         shade_enable_ff      <= 1'b0;
         max_height_ff        <= '0;
         min_height_ff        <= '0;
         min_real_height_ff   <= '0;
         total_real_height_ff <= 24'd256;
      end else if (csr_write_enable) begin
         case (csr_index)
            hhc_pkg::REG_COLOR_ENABLE:      color_enable_ff      <= csr_write_data[0];
            hhc_pkg::REG_SHADE_ENABLE:      shade_enable_ff      <= csr_write_data[0];
            hhc_pkg::REG_MAX_HEIGHT:        max_height_ff        <= csr_write_data[15:0];
            hhc_pkg::REG_MIN_HEIGHT:        min_height_ff        <= csr_write_data[15:0];
            hhc_pkg::REG_MIN_REAL_HEIGHT:   min_real_height_ff   <= csr_write_data[23:0];
            hhc_pkg::REG_TOTAL_REAL_HEIGHT: total_real_height_ff <= csr_write_data[23:0];
            default: ;
         endcase
      end
   end

   assign en        = !skid_full_ff;
   assign req_ready = en;

   // ---------------- stage 1 ----------------
   always_comb begin
      prep_in = '0;
      neg_z   = 17'd0 - {req_source_height[15], req_source_height};
      min_mag = min_height_ff[15] ? 17'd0 - {min_height_ff[15], min_height_ff}
                                  : {1'b0, min_height_ff};
      mr_mag  = min_real_height_ff[23] ? 24'd0 - $unsigned(min_real_height_ff)
                                       : $unsigned(min_real_height_ff);

      prep_in.hue_mode = hhc_pkg::HUE_FIXED;
      if (color_enable_ff) begin
         if (!req_source_height[15]) begin
            if (max_height_ff[15] || max_height_ff == '0) begin
               prep_in.hue_mode = hhc_pkg::HUE_FIXED;
            end else if (req_source_height >= max_height_ff) begin
               prep_in.hue_mode = hhc_pkg::HUE_ZERO;
            end else begin
               prep_in.hue_mode = hhc_pkg::HUE_POS;
               prep_in.hue_num  = {1'b0, 16'(max_height_ff - req_source_height)};
               prep_in.hue_den  = {1'b0, max_height_ff};
            end
         end else if (min_height_ff == '0) begin
            prep_in.hue_mode = hhc_pkg::HUE_FIXED;
         end else if (neg_z >= min_mag) begin
            prep_in.hue_mode = hhc_pkg::HUE_FULL;
         end else begin
            prep_in.hue_mode = hhc_pkg::HUE_NEG;
            prep_in.hue_num  = neg_z;
            prep_in.hue_den  = min_mag;
         end
      end

      if (!shade_enable_ff) begin
         prep_in.bright_mode = hhc_pkg::BRIGHT_FIXED;
      end else if (total_real_height_ff == '0) begin
         prep_in.bright_mode = hhc_pkg::BRIGHT_ONE;
      end else begin
         prep_in.bright_mode = hhc_pkg::BRIGHT_DIV;
      end
      prep_in.sum = {req_real_height[23], req_real_height} + {1'b0, mr_mag};
   end

   // ---------------- stage 2 ----------------
   always_comb begin
      div_src_in             = '0;
      div_src_in.hue_mode    = prep_ff.hue_mode;
      div_src_in.bright_mode = prep_ff.bright_mode;
      sum_mag = prep_ff.sum[24] ? 25'd0 - prep_ff.sum : prep_ff.sum;
      if (prep_ff.hue_mode == hhc_pkg::HUE_NEG) begin
         div_src_in.hue_rem = 24'(prep_ff.hue_num) * 24'd280 + 24'(prep_ff.hue_den);
      end else begin
         div_src_in.hue_rem = 24'(prep_ff.hue_num) * 24'd180 + 24'(prep_ff.hue_den);
      end
      div_src_in.hue_den = {prep_ff.hue_den[15:0], 1'b0};
      // numerator |s| * 65536 plus half the divisor for round-to-nearest
      div_src_in.br_rem  = {1'b0, sum_mag[23:0], 16'd0}
                         + {{(hhc_pkg::BrNumW-hhc_pkg::TotW+1){1'b0}},
                            total_real_height_ff[hhc_pkg::TotW-1:1]};
   end

   hhc_div_pipe u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s2_vld_ff),
      .in_data  (div_src_ff),
      .total    (total_real_height_ff),
      .out_vld  (div_out_vld),
      .out_data (div_out)
   );

   // ---------------- stage 3 ----------------
   always_comb begin
      hue_neg_sum = hhc_pkg::HueNegBase + {1'b0, div_out.hue_quo};
      case (div_out.hue_mode)
         hhc_pkg::HUE_ZERO: s3_hue_in = '0;
         hhc_pkg::HUE_FULL: s3_hue_in = hhc_pkg::HueTop;
         hhc_pkg::HUE_POS:  s3_hue_in = div_out.hue_quo;
         hhc_pkg::HUE_NEG:  s3_hue_in = hue_neg_sum[hhc_pkg::HueW] ? hhc_pkg::HueTop
                                                                  : hue_neg_sum[7:0];
         default:           s3_hue_in = hhc_pkg::HueGrey;
      endcase

      bright_q = (div_out.br_sat || div_out.br_quo > hhc_pkg::OneQ16) ? hhc_pkg::OneQ16
                                                                     : div_out.br_quo;
      case (div_out.bright_mode)
         hhc_pkg::BRIGHT_ONE: s3_bright_in = hhc_pkg::OneQ16;
         hhc_pkg::BRIGHT_DIV: s3_bright_in = (bright_q < hhc_pkg::BrightFloorQ16)
                                             ? hhc_pkg::BrightFloorQ16 : bright_q;
         default:             s3_bright_in = hhc_pkg::BrightFixedQ16;
      endcase
   end

   // ---------------- stage 4 ----------------
   always_comb begin
      sat          = color_enable_ff ? hhc_pkg::SatQ16 : 16'd0;
      chroma_full  = {16'd0, s3_bright_ff} * {17'd0, sat} + 33'd32768;
      s4_chroma_in = chroma_full[31:16];
      if (s3_hue_ff >= 8'd240) begin
         hue_mod = 7'(s3_hue_ff - 8'd240);
      end else if (s3_hue_ff >= 8'd120) begin
         hue_mod = 7'(s3_hue_ff - 8'd120);
      end else begin
         hue_mod = s3_hue_ff[6:0];
      end
      // 60 - |m - 60|
      s4_weight_in = (hue_mod < 7'd60) ? hue_mod[5:0] : 6'(7'd120 - hue_mod);
   end

   // ---------------- stage 5 ----------------
   always_comb begin
      s5_min_in  = s4_bright_ff - {1'b0, s4_chroma_ff};
      s5_xnum_in = 22'(s4_chroma_ff) * 22'(s4_weight_ff) + 22'd30;
   end

   // ---------------- stage 6 ----------------
   always_comb begin
      x_prod  = 45'(s5_xnum_ff) * 45'(hhc_pkg::XRecip);
      s6_x_in = x_prod[hhc_pkg::XShift +: hhc_pkg::ChromaW];
   end

   // ---------------- stage 7 ----------------
   always_comb begin
      ch_cm = to_channel(s6_bright_ff);
      ch_xm = to_channel(s6_min_ff + {1'b0, s6_x_ff});
      ch_mm = to_channel(s6_min_ff);
      if (s6_hue_ff <= 8'd60) begin
         s7_rgb_in = {ch_cm, ch_xm, ch_mm};
      end else if (s6_hue_ff <= 8'd120) begin
         s7_rgb_in = {ch_xm, ch_cm, ch_mm};
      end else if (s6_hue_ff <= 8'd180) begin
         s7_rgb_in = {ch_mm, ch_cm, ch_xm};
      end else if (s6_hue_ff <= 8'd240) begin
         s7_rgb_in = {ch_mm, ch_xm, ch_cm};
      end else begin
         s7_rgb_in = {ch_xm, ch_mm, ch_cm};
      end
   end

   // ---------------- pipeline registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= div_out_vld;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prep_ff      <= prep_in;
         div_src_ff   <= div_src_in;
         s3_hue_ff    <= s3_hue_in;
         s3_bright_ff <= s3_bright_in;
         s4_hue_ff    <= s3_hue_ff;
         s4_bright_ff <= s3_bright_ff;
         s4_chroma_ff <= s4_chroma_in;
         s4_weight_ff <= s4_weight_in;
         s5_hue_ff    <= s4_hue_ff;
         s5_bright_ff <= s4_bright_ff;
         s5_min_ff    <= s5_min_in;
         s5_xnum_ff   <= s5_xnum_in;
         s6_hue_ff    <= s5_hue_ff;
         s6_bright_ff <= s5_bright_ff;
         s6_min_ff    <= s5_min_ff;
         s6_x_ff      <= s6_x_in;
         s7_rgb_ff    <= s7_rgb_in;
      end
   end

   // skid: catches the last stage's transaction when the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (rsp_ready) begin
            skid_full_ff <= 1'b0;
         end
      end else if (s7_vld_ff && !rsp_ready) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_rgb_ff <= s7_rgb_ff;
      end
   end

   assign rsp_valid     = skid_full_ff || s7_vld_ff;
   assign rsp_rgb_color = skid_full_ff ? skid_rgb_ff : s7_rgb_ff;

endmodule

FILE: rtl/hhc_checker.sv
// Port-level checks for the height-to-HSV colour block, bound to the top level.
module hhc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [hhc_pkg::RgbW-1:0]     rsp_rgb_color
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rgb_color))
      else $error("result changed or vanished while stalled");

   // input only backs off while a result is waiting
   a_ready_low_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no result pending");

   // the stall must come from a refused transaction in the previous cycle
   a_ready_low_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("req_ready dropped without output back-pressure");

   // reset leaves the pipeline empty and ready
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

endmodule

bind height_to_hsv_color hhc_checker u_hhc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_rgb_color (rsp_rgb_color)
);
